// ===== rtl/core/cpd_pkg.sv =====
// Shared types and constants for the command packet deframer.
// Holds frame marker values and the control/status structs between controller and datapath.
// No dependencies.
package cpd_pkg;

  localparam logic [7:0] MARK_START_A = 8'hFA;
  localparam logic [7:0] MARK_START_B = 8'hFB;
  localparam logic [7:0] MARK_END_A   = 8'hFC;
  localparam logic [7:0] MARK_END_B   = 8'hFD;

  typedef struct packed {
    logic load_command;
    logic load_length;
    logic store_byte;
    logic load_check;
    logic start_data;
    logic start_empty;
    logic fetch;
    logic advance;
  } cpd_cmd_t;

  typedef struct packed {
    logic is_start_a;
    logic is_start_b;
    logic is_end_a;
    logic is_end_b;
    logic byte_zero;
    logic fill_full;
    logic fill_done;
    logic check_ok;
    logic length_zero;
    logic emit_last;
  } cpd_status_t;

endpackage

// ===== rtl/core/cpd_ctrl.sv =====
// Frame controller of the command packet deframer.
// Tracks the frame phase and sequences the result run; depends on cpd_pkg.
module cpd_ctrl
  import cpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_stall,
  output logic        cmd_valid,
  input  logic        cmd_stall,
  input  cpd_status_t status,
  output cpd_cmd_t    ctl
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_START_B = 4'd1;
  localparam logic [3:0] ST_CODE    = 4'd2;
  localparam logic [3:0] ST_LEN     = 4'd3;
  localparam logic [3:0] ST_DATA    = 4'd4;
  localparam logic [3:0] ST_CHECK   = 4'd5;
  localparam logic [3:0] ST_END_A   = 4'd6;
  localparam logic [3:0] ST_END_B   = 4'd7;
  localparam logic [3:0] ST_FETCH   = 4'd8;
  localparam logic [3:0] ST_PRESENT = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       rx_take;
  logic       cmd_take;

  assign rx_stall  = (state == ST_FETCH) || (state == ST_PRESENT);
  assign cmd_valid = (state == ST_PRESENT);
  assign rx_take   = rx_valid && !rx_stall;
  assign cmd_take  = cmd_valid && !cmd_stall;

  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      ST_IDLE: begin
        if (rx_take && status.is_start_a) state_next = ST_START_B;
      end
      ST_START_B: begin
        if (rx_take) state_next = status.is_start_b ? ST_CODE : ST_IDLE;
      end
      ST_CODE: begin
        if (rx_take) begin
          ctl.load_command = 1'b1;
          state_next       = ST_LEN;
        end
      end
      ST_LEN: begin
        if (rx_take) begin
          ctl.load_length = 1'b1;
          state_next      = status.byte_zero ? ST_CHECK : ST_DATA;
        end
      end
      ST_DATA: begin
        if (rx_take) begin
          if (status.fill_full) begin
            state_next = ST_IDLE;
          end else begin
            ctl.store_byte = 1'b1;
            if (status.fill_done) state_next = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (rx_take) begin
          ctl.load_check = 1'b1;
          state_next     = ST_END_A;
        end
      end
      ST_END_A: begin
        if (rx_take) state_next = status.is_end_a ? ST_END_B : ST_IDLE;
      end
      ST_END_B: begin
        if (rx_take) begin
          if (status.is_end_b && status.check_ok) begin
            if (status.length_zero) begin
              ctl.start_empty = 1'b1;
              state_next      = ST_PRESENT;
            end else begin
              ctl.start_data = 1'b1;
              state_next     = ST_FETCH;
            end
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_FETCH: begin
        ctl.fetch  = 1'b1;
        state_next = ST_PRESENT;
      end
      ST_PRESENT: begin
        if (cmd_take) begin
          if (status.emit_last) begin
            state_next = ST_IDLE;
          end else begin
            ctl.advance = 1'b1;
            state_next  = ST_FETCH;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/cpd_datapath.sv =====
// Datapath of the command packet deframer.
// Holds frame fields, the payload buffer, the checksum and the result index; depends on cpd_pkg.
module cpd_datapath
  import cpd_pkg::*;
#(
  parameter int BUFFER_BYTES = 64
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  rx_byte,
  input  cpd_cmd_t    ctl,
  output cpd_status_t status,
  output logic [7:0]  command,
  output logic [6:0]  payload_length,
  output logic        has_data,
  output logic [5:0]  byte_position,
  output logic [7:0]  payload_byte,
  output logic        last
);

  localparam int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
  localparam int CW = $clog2(BUFFER_BYTES + 1);

  logic [7:0]    payload_store [BUFFER_BYTES];
  logic [7:0]    rd_data;
  logic [7:0]    held_command;
  logic [7:0]    held_length;
  logic [CW-1:0] fill_index;
  logic [CW-1:0] emit_index;
  logic [7:0]    running_check;
  logic [7:0]    received_check;
  logic [31:0]   position_wide;

  always_ff @(posedge clk) begin
    if (ctl.store_byte) begin
      payload_store[fill_index[AW-1:0]] <= rx_byte;
    end
    if (ctl.fetch) begin
      rd_data <= payload_store[emit_index[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_command   <= '0;
      held_length    <= '0;
      fill_index     <= '0;
      emit_index     <= '0;
      running_check  <= '0;
      received_check <= '0;
      has_data       <= 1'b0;
    end else begin
      if (ctl.load_command) held_command <= rx_byte;
      if (ctl.load_length) begin
        held_length   <= rx_byte;
        running_check <= held_command ^ rx_byte;
        fill_index    <= '0;
      end
      if (ctl.store_byte) begin
        fill_index    <= fill_index + CW'(1);
        running_check <= running_check ^ rx_byte;
      end
      if (ctl.load_check) received_check <= rx_byte;
      if (ctl.start_data || ctl.start_empty) begin
        emit_index <= '0;
        has_data   <= ctl.start_data;
      end
      if (ctl.advance) emit_index <= emit_index + CW'(1);
    end
  end

  assign status.is_start_a  = (rx_byte == MARK_START_A);
  assign status.is_start_b  = (rx_byte == MARK_START_B);
  assign status.is_end_a    = (rx_byte == MARK_END_A);
  assign status.is_end_b    = (rx_byte == MARK_END_B);
  assign status.byte_zero   = (rx_byte == 8'd0);
  assign status.fill_full   = (fill_index >= CW'(BUFFER_BYTES));
  assign status.fill_done   = ((9'(fill_index) + 9'd1) >= 9'(held_length));
  assign status.check_ok    = (running_check == received_check);
  assign status.length_zero = (held_length == 8'd0);
  assign status.emit_last   = last;

  assign position_wide  = 32'(emit_index);
  assign command        = held_command;
  assign payload_length = held_length[6:0];
  assign byte_position  = position_wide[5:0];
  assign payload_byte   = has_data ? rd_data : 8'd0;
  assign last           = !has_data || ((9'(emit_index) + 9'd1) == 9'(held_length));

endmodule

// ===== rtl/core/command_packet_deframer.sv =====
// Top level of the command packet deframer.
// Joins the frame controller and the datapath; depends on cpd_pkg, cpd_ctrl, cpd_datapath.
//
//   Channel  Handshake             Payload
//   rx       rx_valid / rx_stall   rx_byte
//   cmd      cmd_valid / cmd_stall command, payload_length, has_data, byte_position,
//                                  payload_byte, last
//
// One received byte is taken per cycle while a frame is being parsed.
// A good frame with payload then emits its results, each as a buffer read followed by
// presentation; an empty frame emits its single result without a buffer read.
// Input is stalled for the whole run.
// A stall on the result channel holds the current item and extends the run.
// Reset is synchronous and returns the block to waiting for a start marker.
module command_packet_deframer
  import cpd_pkg::*;
#(
  parameter int BUFFER_BYTES = 64
)
(
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  output logic       cmd_valid,
  input  logic       cmd_stall,
  output logic [7:0] command,
  output logic [6:0] payload_length,
  output logic       has_data,
  output logic [5:0] byte_position,
  output logic [7:0] payload_byte,
  output logic       last
);

  cpd_cmd_t    ctl;
  cpd_status_t status;

  cpd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .rx_valid  (rx_valid),
    .rx_stall  (rx_stall),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .status    (status),
    .ctl       (ctl)
  );

  cpd_datapath #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .rx_byte        (rx_byte),
    .ctl            (ctl),
    .status         (status),
    .command        (command),
    .payload_length (payload_length),
    .has_data       (has_data),
    .byte_position  (byte_position),
    .payload_byte   (payload_byte),
    .last           (last)
  );

  // Input must be held off while any result is shown.
  assert property (@(posedge clk) disable iff (rst) cmd_valid |-> rx_stall)
    else $error("input not stalled during result run");

  // A result without data always ends its frame.
  assert property (@(posedge clk) disable iff (rst) (cmd_valid && !has_data) |-> last)
    else $error("empty frame result without last");

  // After a non-final result is taken, the next cycle is a buffer read.
  assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall && !last) |=> (!cmd_valid && rx_stall))
    else $error("result run did not continue with a buffer read");

  // After the final result is taken, input is open again.
  assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall && last) |=> !rx_stall)
    else $error("input still stalled after last result");

endmodule

// ===== tb/tb_command_packet_deframer.sv =====
// Self-checking testbench for command_packet_deframer: drives byte streams of good,
// broken and oversized command frames and checks every result item against a
// built-in frame parser. Depends on cpd_pkg and the deframer RTL.
`timescale 1ns / 100ps

module tb_command_packet_deframer;
  import cpd_pkg::*;

  localparam int BUFFER_BYTES = 64;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 20;

  typedef enum logic [2:0] {
    WAIT_START_A,
    WAIT_START_B,
    GET_CODE,
    GET_LENGTH,
    GET_PAYLOAD,
    GET_CHECK,
    WAIT_END_A,
    WAIT_END_B
  } parse_phase_t;

  typedef enum logic [1:0] {
    FAULT_START_B,
    FAULT_CHECKSUM,
    FAULT_END_A,
    FAULT_END_B
  } frame_fault_t;

  typedef struct packed {
    logic [7:0] command;
    logic [6:0] payload_length;
    logic       has_data;
    logic [5:0] byte_position;
    logic [7:0] payload_byte;
    logic       last;
  } frame_result_t;

  logic       clk;
  logic       rst;
  logic       rx_valid;
  logic       rx_stall;
  logic [7:0] rx_byte;
  logic       cmd_valid;
  logic       cmd_stall;
  logic [7:0] command;
  logic [6:0] payload_length;
  logic       has_data;
  logic [5:0] byte_position;
  logic [7:0] payload_byte;
  logic       last;

  parse_phase_t  parse_phase;
  logic [7:0]    held_code;
  logic [7:0]    held_len;
  logic [7:0]    payload_mem [BUFFER_BYTES];
  int            fill_count;
  logic [7:0]    run_xor;
  logic [7:0]    rx_check;

  frame_result_t pending_results [$];
  frame_result_t want;
  logic [7:0]    frame_bytes [$];

  int sender_idle_pct;
  int receiver_stall_pct;
  int holdoff_left;
  int bytes_sent;
  int results_checked;
  int frames_delivered;
  int mismatch_count;
  int quiet_cycles;

  command_packet_deframer #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .rx_valid(rx_valid),
    .rx_stall(rx_stall),
    .rx_byte(rx_byte),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .command(command),
    .payload_length(payload_length),
    .has_data(has_data),
    .byte_position(byte_position),
    .payload_byte(payload_byte),
    .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    if (mismatch_count < 30) begin
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, exp_val);
    end
    mismatch_count++;
  endtask

  task automatic track_rx_byte(input logic [7:0] b);
    frame_result_t r;
    int n;
    case (parse_phase)
      WAIT_START_A: begin
        if (b == MARK_START_A) parse_phase = WAIT_START_B;
      end
      WAIT_START_B: begin
        parse_phase = (b == MARK_START_B) ? GET_CODE : WAIT_START_A;
      end
      GET_CODE: begin
        held_code = b;
        parse_phase = GET_LENGTH;
      end
      GET_LENGTH: begin
        held_len = b;
        run_xor = held_code ^ b;
        fill_count = 0;
        parse_phase = (b != 8'd0) ? GET_PAYLOAD : GET_CHECK;
      end
      GET_PAYLOAD: begin
        if (fill_count < BUFFER_BYTES && fill_count < held_len) begin
          payload_mem[fill_count] = b;
          fill_count++;
          run_xor = run_xor ^ b;
          if (fill_count >= held_len) parse_phase = GET_CHECK;
        end else begin
          parse_phase = WAIT_START_A;
        end
      end
      GET_CHECK: begin
        rx_check = b;
        parse_phase = WAIT_END_A;
      end
      WAIT_END_A: begin
        parse_phase = (b == MARK_END_A) ? WAIT_END_B : WAIT_START_A;
      end
      default: begin
        if (b == MARK_END_B && run_xor == rx_check) begin
          r.command = held_code;
          r.payload_length = held_len[6:0];
          if (held_len == 8'd0) begin
            r.has_data = 1'b0;
            r.byte_position = '0;
            r.payload_byte = '0;
            r.last = 1'b1;
            pending_results.push_back(r);
          end else begin
            n = (held_len > BUFFER_BYTES) ? BUFFER_BYTES : int'(held_len);
            for (int i = 0; i < n; i++) begin
              r.has_data = 1'b1;
              r.byte_position = 6'(i);
              r.payload_byte = payload_mem[i];
              r.last = (i + 1 == n);
              pending_results.push_back(r);
            end
          end
        end
        parse_phase = WAIT_START_A;
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      parse_phase = WAIT_START_A;
      held_code = '0;
      held_len = '0;
      fill_count = 0;
      run_xor = '0;
      rx_check = '0;
    end else if (rx_valid && !rx_stall) begin
      track_rx_byte(rx_byte);
    end
  end

  always @(posedge clk) begin
    if (!rst && cmd_valid && !cmd_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result item", payload_byte, 0);
      end else begin
        want = pending_results.pop_front();
        if (command != want.command) report_mismatch("command", command, want.command);
        if (payload_length != want.payload_length) begin
          report_mismatch("payload_length", payload_length, want.payload_length);
        end
        if (has_data != want.has_data) report_mismatch("has_data", has_data, want.has_data);
        if (byte_position != want.byte_position) begin
          report_mismatch("byte_position", byte_position, want.byte_position);
        end
        if (payload_byte != want.payload_byte) begin
          report_mismatch("payload_byte", payload_byte, want.payload_byte);
        end
        if (last != want.last) report_mismatch("last", last, want.last);
        results_checked++;
        if (want.last) frames_delivered++;
      end
    end
  end

  always @(posedge clk) begin
    if ((rx_valid && !rx_stall) || (cmd_valid && !cmd_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Watchdog expired: no item moved in %0d cycles.", STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    cmd_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_left > 0) begin
        holdoff_left--;
        cmd_stall <= 1'b1;
      end else begin
        cmd_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      rx_valid <= 1'b0;
      @(negedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (rx_stall) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  function automatic void make_frame(input logic [7:0] code, input int len);
    logic [7:0] sum;
    logic [7:0] data;
    frame_bytes.delete();
    frame_bytes.push_back(MARK_START_A);
    frame_bytes.push_back(MARK_START_B);
    frame_bytes.push_back(code);
    frame_bytes.push_back(8'(len));
    sum = code ^ 8'(len);
    for (int i = 0; i < len; i++) begin
      data = 8'($urandom_range(0, 255));
      frame_bytes.push_back(data);
      sum = sum ^ data;
    end
    frame_bytes.push_back(sum);
    frame_bytes.push_back(MARK_END_A);
    frame_bytes.push_back(MARK_END_B);
  endfunction

  task automatic send_frame();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
  endtask

  task automatic test_directed_frames();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    send_byte(8'h00);
    send_byte(8'hFF);
    make_frame(8'hFF, 0);
    send_frame();
    send_byte(MARK_START_A);
    send_byte(MARK_START_A);
    send_byte(MARK_START_B);
    send_byte(MARK_START_A);
    send_byte(MARK_START_B);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'hFF);
    send_byte(8'hFE);
    send_byte(MARK_END_A);
    send_byte(MARK_END_B);
  endtask

  task automatic test_buffer_limits();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    make_frame(8'($urandom_range(0, 255)), BUFFER_BYTES);
    send_frame();
    make_frame(8'($urandom_range(0, 255)), BUFFER_BYTES + 1);
    send_frame();
  endtask

  task automatic test_result_backpressure();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    holdoff_left = 300;
    repeat (3) begin
      make_frame(8'($urandom_range(0, 255)), 8);
      send_frame();
    end
  endtask

  task automatic test_random_traffic(input int send_pct, input int stall_pct, input int n_items);
    int first_count;
    int pick;
    int len;
    int pos;
    frame_fault_t fault;
    sender_idle_pct = send_pct;
    receiver_stall_pct = stall_pct;
    first_count = bytes_sent;
    while (bytes_sent - first_count < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, BUFFER_BYTES)
                                            : $urandom_range(0, 8);
        make_frame(8'($urandom_range(0, 255)), len);
        if (pick < 27) begin
          fault = frame_fault_t'($urandom_range(0, 3));
          case (fault)
            FAULT_START_B:  pos = 1;
            FAULT_CHECKSUM: pos = frame_bytes.size() - 3;
            FAULT_END_A:    pos = frame_bytes.size() - 2;
            default:        pos = frame_bytes.size() - 1;
          endcase
          frame_bytes[pos] = frame_bytes[pos] ^ 8'($urandom_range(1, 255));
        end
        send_frame();
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    rx_valid = 1'b0;
    rx_byte = 8'h00;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    holdoff_left = 0;
    bytes_sent = 0;
    results_checked = 0;
    frames_delivered = 0;
    mismatch_count = 0;
    quiet_cycles = 0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    test_directed_frames();
    test_buffer_limits();
    test_result_backpressure();
    test_random_traffic(0, 0, 60);
    test_random_traffic(82, 0, 60);
    test_random_traffic(0, 82, 60);
    test_random_traffic(28, 28, 60);

    rx_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes of good, corrupted, oversized and noise traffic.", bytes_sent);
    $display("Checked %0d result items from %0d delivered frames, %0d mismatches.",
             results_checked, frames_delivered, mismatch_count);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
